// ===== rtl/core/a85_pkg.sv =====
// Shared types and constants for the Ascii85 stream encoder.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package a85_pkg;

  localparam logic FUNC_DATA   = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [7:0] CH_OFFSET = 8'h21;
  localparam logic [7:0] CH_ZGRP   = 8'h7A;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic [6:0] ZERO_COL_LIMIT  = 7'd76;
  localparam logic [6:0] GROUP_COL_LIMIT = 7'd80;
  localparam logic [6:0] ZGRP_COLS       = 7'd1;
  localparam logic [6:0] GROUP_COLS      = 7'd5;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIG_W      = 7;
  localparam logic [6:0]  BASE       = 7'd85;

  // floor(x / 85) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP       = 32'd3233857729;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUO_W       = 64 - RECIP_SHIFT;

  // one conversion step per cycle: a leading divide plus one step per digit
  localparam logic [2:0] CV_STEPS = 3'd6;

  localparam int unsigned FIFO_DEPTH = 2;

  typedef struct packed {
    logic [2:0] ndig;
    logic       zgrp;
    logic       nl;
    logic       tail;
  } ctl_t;

  typedef struct packed {
    logic [31:0] value;
    ctl_t        ctl;
  } job_t;

  typedef logic [DIG_W-1:0] digit_t;

endpackage

`default_nettype wire

// ===== rtl/core/a85_front.sv =====
// Front end: accepts input beats, packs bytes into groups, tracks the line
// column and pushes one job per group or finish. Depends on a85_pkg.
`default_nettype none

module a85_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          func_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          full_i,
  output logic               push_o,
  output a85_pkg::job_t      job_o
);

  logic [23:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [6:0]  col_q, col_d;
  logic [31:0] word;
  logic [6:0]  col_sum;
  logic        accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign word       = {acc_q, data_byte_i};

  always_comb begin
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    col_d        = col_q;
    push_o       = 1'b0;
    col_sum      = col_q;
    job_o.value  = word;
    job_o.ctl    = '0;
    if (accept) begin
      if (func_i == a85_pkg::FUNC_FINISH) begin
        push_o         = 1'b1;
        job_o.ctl.tail = 1'b1;
        case (cnt_q)
          2'd1: begin
            job_o.value    = {acc_q[7:0], 24'd0};
            job_o.ctl.ndig = 3'd2;
          end
          2'd2: begin
            job_o.value    = {acc_q[15:0], 16'd0};
            job_o.ctl.ndig = 3'd3;
          end
          2'd3: begin
            job_o.value    = {acc_q[23:0], 8'd0};
            job_o.ctl.ndig = 3'd4;
          end
          default: begin
            job_o.ctl.ndig = 3'd0;
          end
        endcase
        acc_d = '0;
        cnt_d = '0;
        col_d = '0;
      end else if (cnt_q == 2'd3) begin
        push_o = 1'b1;
        if (word == 32'd0) begin
          job_o.ctl.zgrp = 1'b1;
          col_sum        = col_q + a85_pkg::ZGRP_COLS;
          job_o.ctl.nl   = (col_sum >= a85_pkg::ZERO_COL_LIMIT);
        end else begin
          job_o.ctl.ndig = 3'(a85_pkg::NUM_DIGITS);
          col_sum        = col_q + a85_pkg::GROUP_COLS;
          job_o.ctl.nl   = (col_sum >= a85_pkg::GROUP_COL_LIMIT);
        end
        col_d = job_o.ctl.nl ? 7'd0 : col_sum;
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = {acc_q[15:0], data_byte_i};
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      col_q <= '0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      col_q <= col_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/a85_fifo.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on a85_pkg for the job type and depth.
`default_nettype none

module a85_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire a85_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               avail_o,
  output a85_pkg::job_t      job_o
);

  a85_pkg::job_t mem_q [a85_pkg::FIFO_DEPTH];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'(a85_pkg::FIFO_DEPTH));
  assign avail_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;

  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/a85_back.sv =====
// Back end: turns a job's group into base-85 digits by reciprocal multiply,
// then emits its characters one beat per cycle while ready. Depends on a85_pkg.
`default_nettype none

module a85_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire a85_pkg::job_t job_i,
  input  wire logic          avail_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               last_char_o
);

  // conversion stage
  logic                 cv_full_q, cv_full_d;
  logic [2:0]           cv_cnt_q, cv_cnt_d;
  a85_pkg::ctl_t        cv_ctl_q;
  logic [31:0]          x_q;
  logic [31:0]          prev_q;
  a85_pkg::digit_t      cv_dig_q [a85_pkg::NUM_DIGITS];
  logic [63:0]          prod;
  logic [31:0]          x_next;
  a85_pkg::digit_t      rem;
  logic                 cv_run;
  logic                 cv_done;

  // emit stage
  logic                 em_full_q, em_full_d;
  logic [2:0]           pos_q, pos_d;
  a85_pkg::ctl_t        em_ctl_q;
  a85_pkg::digit_t      em_dig_q [a85_pkg::NUM_DIGITS];
  logic [3:0]           em_len;
  logic [2:0]           tail_pos;
  logic                 em_fire;
  logic                 em_load;

  assign prod   = {32'd0, x_q} * {32'd0, a85_pkg::RECIP};
  assign x_next = 32'(prod[63:a85_pkg::RECIP_SHIFT]);
  assign rem    = prev_q[a85_pkg::DIG_W-1:0]
                - a85_pkg::digit_t'(x_q[a85_pkg::DIG_W-1:0] * a85_pkg::BASE);

  assign cv_run  = cv_full_q && (cv_ctl_q.ndig != 3'd0) && (cv_cnt_q != a85_pkg::CV_STEPS);
  assign cv_done = cv_full_q && !cv_run;

  assign em_len = 4'(em_ctl_q.zgrp) + 4'(em_ctl_q.ndig) + 4'(em_ctl_q.nl)
                + (em_ctl_q.tail ? 4'd3 : 4'd0);
  assign last_char_o = ({1'b0, pos_q} == (em_len - 4'd1));
  assign out_valid_o = em_full_q;
  assign em_fire     = em_full_q && out_ready_i;
  assign em_load     = cv_done && (!em_full_q || (em_fire && last_char_o));
  assign pop_o       = avail_i && (!cv_full_q || em_load);
  assign tail_pos    = pos_q - em_ctl_q.ndig;

  always_comb begin
    if (em_ctl_q.zgrp) begin
      out_char_o = (pos_q == 3'd0) ? a85_pkg::CH_ZGRP : a85_pkg::CH_NL;
    end else if (pos_q < em_ctl_q.ndig) begin
      out_char_o = 8'(em_dig_q[pos_q]) + a85_pkg::CH_OFFSET;
    end else if (em_ctl_q.tail) begin
      case (tail_pos)
        3'd0:    out_char_o = a85_pkg::CH_TILDE;
        3'd1:    out_char_o = a85_pkg::CH_GT;
        default: out_char_o = a85_pkg::CH_NL;
      endcase
    end else begin
      out_char_o = a85_pkg::CH_NL;
    end
  end

  always_comb begin
    cv_full_d = cv_full_q;
    cv_cnt_d  = cv_cnt_q;
    em_full_d = em_full_q;
    pos_d     = pos_q;
    if (pop_o) begin
      cv_full_d = 1'b1;
      cv_cnt_d  = '0;
    end else if (em_load) begin
      cv_full_d = 1'b0;
    end else if (cv_run) begin
      cv_cnt_d = cv_cnt_q + 3'd1;
    end
    if (em_load) begin
      em_full_d = 1'b1;
      pos_d     = '0;
    end else if (em_fire) begin
      if (last_char_o) begin
        em_full_d = 1'b0;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q      <= job_i.value;
      cv_ctl_q <= job_i.ctl;
    end else if (cv_run) begin
      x_q    <= x_next;
      prev_q <= x_q;
      // digits arrive least significant first: shift toward the high end
      if (cv_cnt_q != 3'd0) begin
        cv_dig_q[0] <= rem;
        for (int i = 1; i < a85_pkg::NUM_DIGITS; i++) begin
          cv_dig_q[i] <= cv_dig_q[i-1];
        end
      end
    end
    if (em_load) begin
      em_ctl_q <= cv_ctl_q;
      em_dig_q <= cv_dig_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_full_q <= 1'b0;
      cv_cnt_q  <= '0;
      em_full_q <= 1'b0;
      pos_q     <= '0;
    end else begin
      cv_full_q <= cv_full_d;
      cv_cnt_q  <= cv_cnt_d;
      em_full_q <= em_full_d;
      pos_q     <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ascii85_stream_encoder.sv =====
// Ascii85 stream encoder top level: front end, job queue, back end.
// Depends on a85_pkg, a85_front, a85_fifo and a85_back.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | sink      | in_valid_i/in_ready_o  | func_i, data_byte_i
//   out     | source    | out_valid_o/out_ready_i| out_char_o, last_char_o
//
// Input beats are taken one per cycle while the two-entry job queue has room.
// A nonzero group runs through the shared divide-by-85 multiplier loop, then
// hands over to the emit stage; conversion overlaps with emission of the
// previous job, so the back end takes in a new group before the characters
// of the last one are all out.
// Reset clears the control state at once; data registers are not reset. A stalled output holds
// the emit stage, then conversion, then the queue, then the input.
`default_nettype none

module ascii85_stream_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       func_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            last_char_o
);

  a85_pkg::job_t push_job;
  a85_pkg::job_t pop_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          avail;

  a85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  a85_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .job_o   (pop_job)
  );

  a85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .avail_i     (avail),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_ascii85_stream_encoder.sv =====
// Self-checking testbench for ascii85_stream_encoder: directed table, a line-limit case, then random byte streams.
// Predicts every output beat locally under sender gaps, receiver stalls and back-pressure.
// Depends on a85_pkg and ascii85_stream_encoder.
`default_nettype none

module tb_ascii85_stream_encoder;

  localparam logic [7:0] DIG_OFFSET  = 8'h21;
  localparam logic [7:0] ZERO_GROUP  = 8'h7A;
  localparam logic [7:0] TILDE       = 8'h7E;
  localparam logic [7:0] GREATER     = 8'h3E;
  localparam logic [7:0] NEWLINE     = 8'h0A;
  localparam int         ZERO_WRAP   = 76;
  localparam int         GROUP_WRAP  = 80;
  localparam int         HOLD_CYCLES = 150;

  typedef struct packed {
    logic        func;
    logic [7:0]  data;
    logic [63:0] chars;
  } row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  localparam int NUM_ROWS = 25;
  localparam row_t DIRECTED [0:NUM_ROWS-1] = '{
    '{a85_pkg::FUNC_FINISH, 8'h00, "~>\n"},
    '{a85_pkg::FUNC_DATA,   8'h00, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h00, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h00, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h00, "z"},
    '{a85_pkg::FUNC_DATA,   8'hFF, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'hFF, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'hFF, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'hFF, "s8W-!"},
    '{a85_pkg::FUNC_FINISH, 8'hA5, "~>\n"},
    '{a85_pkg::FUNC_DATA,   8'h01, 64'h0},
    '{a85_pkg::FUNC_FINISH, 8'h00, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h55, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'hAA, 64'h0},
    '{a85_pkg::FUNC_FINISH, 8'hFF, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h12, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h34, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h56, 64'h0},
    '{a85_pkg::FUNC_FINISH, 8'h5A, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h00, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h00, 64'h0},
    '{a85_pkg::FUNC_DATA,   8'h00, 64'h0},
    '{a85_pkg::FUNC_FINISH, 8'h00, "!!!!~>\n"},
    '{a85_pkg::FUNC_DATA,   8'hFF, 64'h0},
    '{a85_pkg::FUNC_FINISH, 8'h00, 64'h0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       func_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       last_char_o;

  ascii85_stream_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  logic [31:0] grp_acc;
  int          grp_cnt;
  int          line_col;
  logic [7:0]  item_chars [$];
  out_beat_t   expected_chars [$];
  out_beat_t   got;
  int          mismatches;
  int          beats_sent;
  int          gap_pct;
  int          stall_pct;
  int          hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("ascii85_stream_encoder: mismatch");
    $finish;
  end

  task automatic push_digits(input logic [31:0] v, input int cnt);
    logic [7:0]  dig [5];
    logic [31:0] rem;
    rem = v;
    for (int i = 4; i >= 0; i--) begin
      dig[i] = 8'(rem % 85) + DIG_OFFSET;
      rem    = rem / 85;
    end
    for (int i = 0; i < cnt; i++) item_chars.push_back(dig[i]);
  endtask

  task automatic encode_item(input logic f, input logic [7:0] b);
    if (f == a85_pkg::FUNC_DATA) begin
      grp_acc = {grp_acc[23:0], b};
      grp_cnt++;
      if (grp_cnt == 4) begin
        if (grp_acc == 32'h0) begin
          item_chars.push_back(ZERO_GROUP);
          line_col += 1;
          if (line_col >= ZERO_WRAP) begin
            item_chars.push_back(NEWLINE);
            line_col = 0;
          end
        end else begin
          push_digits(grp_acc, 5);
          line_col += 5;
          if (line_col >= GROUP_WRAP) begin
            item_chars.push_back(NEWLINE);
            line_col = 0;
          end
        end
        grp_acc = 32'h0;
        grp_cnt = 0;
      end
    end else begin
      if (grp_cnt != 0) push_digits(grp_acc << ((4 - grp_cnt) * 8), grp_cnt + 1);
      item_chars.push_back(TILDE);
      item_chars.push_back(GREATER);
      item_chars.push_back(NEWLINE);
      grp_acc  = 32'h0;
      grp_cnt  = 0;
      line_col = 0;
    end
  endtask

  task automatic log_expected(input logic f, input logic [7:0] b, input logic [63:0] typed);
    item_chars.delete();
    encode_item(f, b);
    if (typed != 64'h0) begin
      item_chars.delete();
      for (int i = 7; i >= 0; i--) begin
        if (typed[i*8 +: 8] != 8'h00) item_chars.push_back(typed[i*8 +: 8]);
      end
    end
    for (int i = 0; i < item_chars.size(); i++) begin
      expected_chars.push_back('{item_chars[i], i == item_chars.size() - 1});
    end
  endtask

  task automatic send_beat(input logic f, input logic [7:0] b, input logic [63:0] typed);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    log_expected(f, b, typed);
    beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_group(input bit zero, input bit force_nz);
    for (int j = 0; j < 4; j++) begin
      if (zero) send_beat(a85_pkg::FUNC_DATA, 8'h00, 64'h0);
      else if (force_nz && j == 0) begin
        send_beat(a85_pkg::FUNC_DATA, 8'($urandom_range(1, 255)), 64'h0);
      end
      else send_beat(a85_pkg::FUNC_DATA, rand_byte(), 64'h0);
    end
  endtask

  task automatic send_stream(input int max_groups, input int zero_pct);
    int ngroups;
    int ntail;
    ngroups = $urandom_range(0, max_groups);
    ntail   = $urandom_range(0, 3);
    for (int g = 0; g < ngroups; g++) send_group($urandom_range(0, 99) < zero_pct, 1'b0);
    for (int t = 0; t < ntail; t++) send_beat(a85_pkg::FUNC_DATA, rand_byte(), 64'h0);
    if ($urandom_range(0, 9) != 0) begin
      send_beat(a85_pkg::FUNC_FINISH, 8'($urandom_range(0, 255)), 64'h0);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %h last %b",
                 $time, out_char_o, last_char_o);
        mismatches++;
      end else begin
        got = expected_chars.pop_front();
        if (got.ch !== out_char_o) begin
          $display("%0t: out_char expected %h actual %h", $time, got.ch, out_char_o);
          mismatches++;
        end
        if (got.last !== last_char_o) begin
          $display("%0t: last_char expected %b actual %b", $time, got.last, last_char_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int target;
    in_valid_i  = 1'b0;
    func_i      = a85_pkg::FUNC_DATA;
    data_byte_i = 8'h00;
    rst_ni      = 1'b0;
    grp_acc     = 32'h0;
    grp_cnt     = 0;
    line_col    = 0;
    mismatches  = 0;
    beats_sent  = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_beat(DIRECTED[r].func, DIRECTED[r].data, DIRECTED[r].chars);
    end
    drain();

    // land a zero group exactly on the short line limit while the receiver holds off
    hold_cycles = HOLD_CYCLES;
    for (int g = 0; g < 15; g++) send_group(1'b0, 1'b1);
    send_group(1'b1, 1'b0);
    send_beat(a85_pkg::FUNC_FINISH, 8'h00, 64'h0);
    drain();

    for (int p = 0; p < 4; p++) begin
      gap_pct   = (p == 1) ? 58 : (p == 3) ? 31 : 0;
      stall_pct = (p == 2) ? 58 : (p == 3) ? 31 : 0;
      target    = beats_sent + 5;
      while (beats_sent < target) begin
        if ($urandom_range(0, 7) == 0) send_beat(a85_pkg::FUNC_FINISH, rand_byte(), 64'h0);
        else send_stream(1, 30);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ascii85_stream_encoder: match");
    end else begin
      $display("ascii85_stream_encoder: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/a85_pkg.sv
rtl/core/a85_front.sv
rtl/core/a85_fifo.sv
rtl/core/a85_back.sv
rtl/core/ascii85_stream_encoder.sv
verif/tb_ascii85_stream_encoder.sv
